// File: rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the pass timing smoother
// Command and register codes, sizes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Table sizes
  localparam int PASS_SLOTS = 16;
  localparam int MAX_MARKS  = 32;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int STAMP_W    = 64;
  localparam int SLOT_W     = 4;
  localparam int TIME_W     = 32;
  localparam int VBITS_W    = 7;
  localparam int TICK_W     = 32;
  localparam int SMOOTH_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Derived sizes
  localparam int IDX_W  = (PASS_SLOTS > 1) ? $clog2(PASS_SLOTS) : 1;
  localparam int MARK_W = $clog2(MAX_MARKS + 1);
  localparam int PROD_W = 2 * TIME_W;

  // Register reset values
  localparam logic [VBITS_W-1:0]  VBITS_RST  = VBITS_W'(64);
  localparam logic [TICK_W-1:0]   TICK_RST   = TICK_W'(65536);
  localparam logic [SMOOTH_W-1:0] SMOOTH_RST = SMOOTH_W'(1966);

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN = 2'd0,
    CMD_PASS  = 2'd1,
    CMD_END   = 2'd2
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STAMP_BITS  = 2'd0,
    CFG_TICK_PERIOD = 2'd1,
    CFG_SMOOTHING   = 2'd2
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_NS_CALC,
    ST_PASS_UPD,
    ST_SWEEP,
    ST_TOTAL,
    ST_MOVE_MUL,
    ST_MOVE_APPLY,
    ST_DONE
  } state_e;

endpackage

// File: rtl/core/pts_req_if.sv
// ----------------------------------------------------------------------------
// pts_req_if: timestamp event channel
// Valid/ready channel carrying one timestamp event request.
// ----------------------------------------------------------------------------
interface pts_req_if import pts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [STAMP_W-1:0]  stamp_value;
  logic [SLOT_W-1:0]   pass_slot;

  modport source (output valid, command, stamp_value, pass_slot, input ready);
  modport sink   (input valid, command, stamp_value, pass_slot, output ready);
endinterface

// File: rtl/core/pts_rsp_if.sv
// ----------------------------------------------------------------------------
// pts_rsp_if: timing result channel
// Valid/ready channel carrying one result per event request.
// ----------------------------------------------------------------------------
interface pts_rsp_if import pts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  slot_echo;
  logic [TIME_W-1:0]  pass_time_ns;
  logic [TIME_W-1:0]  frame_time_ns;
  logic               taken;

  modport source (output valid, slot_echo, pass_time_ns, frame_time_ns, taken,
                  input ready);
  modport sink   (input valid, slot_echo, pass_time_ns, frame_time_ns, taken,
                  output ready);
endinterface

// File: rtl/core/pts_cfg_if.sv
// ----------------------------------------------------------------------------
// pts_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface pts_cfg_if import pts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/core/pass_timing_smoother.sv
// ----------------------------------------------------------------------------
// pass_timing_smoother: smoothed per-pass and per-frame timings
// Turns timestamp events into per-slot exponential moving averages and a
// smoothed frame total, using one shared 32x32 multiplier under a sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | accepted when
//  req_i   | in  | command, stamp_value, pass_slot                  | valid & ready
//  rsp_o   | out | slot_echo, pass_time_ns, frame_time_ns, taken    | valid & ready
//  cfg_i   | in  | reg_index, wdata                                 | valid & ready
//
//  Begin frame and ignored events go from decode straight to the result load;
//  a pass stamp first runs the low and high multiplies and the ns combine, plus
//  a smoothing move when the slot already holds a value. End frame walks all 16
//  slots one per cycle, but each decayed slot takes a multiply and apply step;
//  the total is then smoothed, or loaded while zero. One request at a time;
//  req ready is high only while the sequencer is idle, reached as the result loads.
//  A result waiting in the output register does not block the next request;
//  only the final load waits for it to drain. Config is always ready.
//  Reset clears the slot table, frame state and config registers to defaults.
// ----------------------------------------------------------------------------
module pass_timing_smoother import pts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  pts_req_if.sink  req_i,
  pts_rsp_if.source rsp_o,
  pts_cfg_if.sink  cfg_i
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PASS_SLOTS - 1);

  // Configuration registers
  logic [VBITS_W-1:0]  vbits_q;
  logic [TICK_W-1:0]   tick_q;
  logic [SMOOTH_W-1:0] smooth_q;

  // Control and frame state
  state_e              state_q, state_d;
  logic [STAMP_W-1:0]  last_q, last_d;
  logic                open_q, open_d;
  logic [MARK_W-1:0]   marks_q, marks_d;
  logic [TIME_W-1:0]   sum_q, sum_d;
  logic [TIME_W-1:0]   total_q, total_d;
  logic [TIME_W-1:0]   slot_time_q [PASS_SLOTS];
  logic [TIME_W-1:0]   slot_time_d [PASS_SLOTS];
  logic [PASS_SLOTS-1:0] known_q, known_d;
  logic [PASS_SLOTS-1:0] seen_q, seen_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                tgt_total_q, tgt_total_d;
  logic                taken_q, taken_d;
  logic                rsp_valid_q, rsp_valid_d;

  // Datapath registers
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [STAMP_W-1:0]  stamp_q, stamp_d;
  logic [SLOT_W-1:0]   in_slot_q, in_slot_d;
  logic [STAMP_W-1:0]  delta_q, delta_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [PROD_W-1:0]   lo_q, lo_d;
  logic [TIME_W-1:0]   ns_q, ns_d;
  logic [TIME_W-1:0]   mv_v_q, mv_v_d;
  logic                up_q, up_d;
  logic [SLOT_W-1:0]   echo_q, echo_d;
  logic [TIME_W-1:0]   ptime_q, ptime_d;
  logic [TIME_W-1:0]   ftime_q, ftime_d;
  logic                rtaken_q, rtaken_d;

  // Shared multiplier operands and helpers
  logic [TIME_W-1:0]   mul_a, mul_b;
  logic [TIME_W-1:0]   slot_rd, s_cur, step, moved;
  logic [STAMP_W-1:0]  mask;
  logic                supported, slot_in_range;
  logic [48:0]         ns_wide;
  logic [TIME_W:0]     sum_wide;

  assign supported     = (vbits_q != '0) && (tick_q != '0);
  assign mask          = (vbits_q >= VBITS_W'(STAMP_W)) ? '1 : ~({STAMP_W{1'b1}} << vbits_q);
  assign slot_in_range = (int'(in_slot_q) < PASS_SLOTS);
  assign slot_rd       = slot_time_q[idx_q];
  assign s_cur         = tgt_total_q ? total_q : slot_rd;
  assign step          = prod_q[TIME_W+15:16];
  assign moved         = up_q ? (s_cur + step) : (s_cur - step);
  assign ns_wide       = 49'({prod_q[15:0], 16'h0000}) + 49'(lo_q[PROD_W-1:16]);
  assign sum_wide      = (TIME_W+1)'(sum_q) + (TIME_W+1)'(ns_q);

  // Shared multiplier, registered
  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign req_i.ready         = (state_q == ST_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.slot_echo     = echo_q;
  assign rsp_o.pass_time_ns  = ptime_q;
  assign rsp_o.frame_time_ns = ftime_q;
  assign rsp_o.taken         = rtaken_q;

  // Sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    open_d      = open_q;
    marks_d     = marks_q;
    sum_d       = sum_q;
    total_d     = total_q;
    slot_time_d = slot_time_q;
    known_d     = known_q;
    seen_d      = seen_q;
    idx_d       = idx_q;
    tgt_total_d = tgt_total_q;
    taken_d     = taken_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    cmd_d       = cmd_q;
    stamp_d     = stamp_q;
    in_slot_d   = in_slot_q;
    delta_d     = delta_q;
    lo_d        = lo_q;
    ns_d        = ns_q;
    mv_v_d      = mv_v_q;
    up_d        = up_q;
    echo_d      = echo_q;
    ptime_d     = ptime_q;
    ftime_d     = ftime_q;
    rtaken_d    = rtaken_q;
    mul_a       = delta_q[TIME_W-1:0];
    mul_b       = tick_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          cmd_d     = req_i.command;
          stamp_d   = req_i.stamp_value;
          in_slot_d = req_i.pass_slot;
          state_d   = ST_DECODE;
        end
      end

      // Decide whether the event is taken and start its work
      ST_DECODE: begin
        taken_d = 1'b0;
        idx_d   = in_slot_q[IDX_W-1:0];
        state_d = ST_DONE;
        if (cmd_q == CMD_BEGIN) begin
          if (supported) begin
            open_d  = 1'b1;
            last_d  = stamp_q;
            marks_d = MARK_W'(1);
            sum_d   = '0;
            seen_d  = '0;
            taken_d = 1'b1;
          end
        end else if (cmd_q == CMD_PASS) begin
          if (supported && open_q && (marks_q < MARK_W'(MAX_MARKS)) && slot_in_range) begin
            delta_d = (stamp_q - last_q) & mask;
            state_d = ST_MUL_LO;
          end
        end else if (cmd_q == CMD_END) begin
          if (supported && open_q && (marks_q >= MARK_W'(2))) begin
            idx_d   = '0;
            state_d = ST_SWEEP;
          end
        end
      end

      // Low word of ticks times period
      ST_MUL_LO: begin
        mul_a   = delta_q[TIME_W-1:0];
        state_d = ST_MUL_HI;
      end

      // High word of ticks times period
      ST_MUL_HI: begin
        lo_d    = prod_q;
        mul_a   = delta_q[STAMP_W-1:TIME_W];
        state_d = ST_NS_CALC;
      end

      // Combine partial products into saturated nanoseconds
      ST_NS_CALC: begin
        if (prod_q[PROD_W-1:16] != '0) begin
          ns_d = '1;
        end else if (ns_wide[48:TIME_W] != '0) begin
          ns_d = '1;
        end else begin
          ns_d = ns_wide[TIME_W-1:0];
        end
        state_d = ST_PASS_UPD;
      end

      // Frame bookkeeping, then set or smooth the slot
      ST_PASS_UPD: begin
        sum_d         = sum_wide[TIME_W] ? '1 : sum_wide[TIME_W-1:0];
        last_d        = stamp_q;
        marks_d       = marks_q + MARK_W'(1);
        seen_d[idx_q] = 1'b1;
        taken_d       = 1'b1;
        if (known_q[idx_q]) begin
          mv_v_d      = ns_q;
          tgt_total_d = 1'b0;
          state_d     = ST_MOVE_MUL;
        end else begin
          slot_time_d[idx_q] = ns_q;
          known_d[idx_q]     = 1'b1;
          state_d            = ST_DONE;
        end
      end

      // Frame end: decay known slots not seen this frame
      ST_SWEEP: begin
        if (known_q[idx_q] && !seen_q[idx_q]) begin
          mv_v_d      = '0;
          tgt_total_d = 1'b0;
          state_d     = ST_MOVE_MUL;
        end else if (idx_q == IDX_LAST) begin
          state_d = ST_TOTAL;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      // Frame total: load directly while zero, else smooth
      ST_TOTAL: begin
        taken_d = 1'b1;
        if (total_q == '0) begin
          total_d = sum_q;
          open_d  = 1'b0;
          state_d = ST_DONE;
        end else begin
          mv_v_d      = sum_q;
          tgt_total_d = 1'b1;
          state_d     = ST_MOVE_MUL;
        end
      end

      // Move toward target: |v - s| times weight
      ST_MOVE_MUL: begin
        up_d    = (mv_v_q >= s_cur);
        mul_a   = (mv_v_q >= s_cur) ? (mv_v_q - s_cur) : (s_cur - mv_v_q);
        mul_b   = TIME_W'(smooth_q);
        state_d = ST_MOVE_APPLY;
      end

      // Apply truncated step and continue
      ST_MOVE_APPLY: begin
        if (tgt_total_q) begin
          total_d = moved;
          open_d  = 1'b0;
          state_d = ST_DONE;
        end else begin
          slot_time_d[idx_q] = moved;
          if (cmd_q != CMD_END) begin
            state_d = ST_DONE;
          end else if (idx_q == IDX_LAST) begin
            state_d = ST_TOTAL;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_SWEEP;
          end
        end
      end

      // Load the result register once it is free
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          echo_d      = (cmd_q == CMD_PASS) ? in_slot_q : '0;
          ptime_d     = ((cmd_q == CMD_PASS) && slot_in_range) ? slot_rd : '0;
          ftime_d     = total_q;
          rtaken_d    = taken_q;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= '0;
      open_q      <= 1'b0;
      marks_q     <= '0;
      sum_q       <= '0;
      total_q     <= '0;
      slot_time_q <= '{default: '0};
      known_q     <= '0;
      seen_q      <= '0;
      idx_q       <= '0;
      tgt_total_q <= 1'b0;
      taken_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      open_q      <= open_d;
      marks_q     <= marks_d;
      sum_q       <= sum_d;
      total_q     <= total_d;
      slot_time_q <= slot_time_d;
      known_q     <= known_d;
      seen_q      <= seen_d;
      idx_q       <= idx_d;
      tgt_total_q <= tgt_total_d;
      taken_q     <= taken_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbits_q  <= VBITS_RST;
      tick_q   <= TICK_RST;
      smooth_q <= SMOOTH_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.reg_index)
        CFG_STAMP_BITS:  vbits_q  <= cfg_i.wdata[VBITS_W-1:0];
        CFG_TICK_PERIOD: tick_q   <= cfg_i.wdata[TICK_W-1:0];
        CFG_SMOOTHING:   smooth_q <= cfg_i.wdata[SMOOTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    stamp_q   <= stamp_d;
    in_slot_q <= in_slot_d;
    delta_q   <= delta_d;
    prod_q    <= prod_d;
    lo_q      <= lo_d;
    ns_q      <= ns_d;
    mv_v_q    <= mv_v_d;
    up_q      <= up_d;
    echo_q    <= echo_d;
    ptime_q   <= ptime_d;
    ftime_q   <= ftime_d;
    rtaken_q  <= rtaken_d;
  end

  // Mark count never passes the limit
  a_marks_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    marks_q <= MARK_W'(MAX_MARKS))
    else $error("mark count above limit");

  // A request is never followed by another in the next cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while busy");

  // A taken frame end leaves the frame closed
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && cmd_q == CMD_END && taken_q) |-> !open_q)
    else $error("frame still open after frame end");

  // A slot moved toward zero never grows
  a_decay_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE_APPLY && !tgt_total_q && mv_v_q == '0)
      |=> slot_time_q[$past(idx_q)] <= $past(slot_rd))
    else $error("slot value grew on decay");

endmodule
